/* rtl/rph_pkg.sv */
// ----------------------------------------------------------------------------
// Readout packet hit parser package
// Shared constants, the record type and the Gray code conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package rph_pkg;

  localparam int RECORD_BYTES = 6;
  localparam int FRAME_LAST   = 3;
  localparam int ID_LAST      = 7;

  localparam logic [31:0] ID_MASK  = 32'hffff_ff00;
  localparam logic [31:0] ID_MAGIC = 32'h564d_3300;

  typedef struct packed {
    logic [31:0] data1;
    logic [15:0] data2;
    logic [3:0]  board;
    logic [31:0] frame;
    logic        bad;
  } rec_t;

  function automatic logic [11:0] gray_to_bin(input logic [11:0] g);
    logic [11:0] b;
    b = '0;
    for (int i = 0; i < 12; i++) begin
      b[i] = ^(g >> i);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/readout_packet_hit_parser.sv */
// Result: a record is registered in the framer once its last byte is accepted,
// then out_valid rises from the output register; other bytes give no result.
// Throughput: one byte per cycle while in_ready is high (output not stalled).
// Reset (rst_n low, synchronous) returns the parser to the packet header and
// clears frame, board and flag state and both valid stages.
// ----------------------------------------------------------------------------
// Readout packet hit parser
// Parses a byte stream of readout packets into hit and marker records.
// ----------------------------------------------------------------------------
`default_nettype none

module readout_packet_hit_parser
  import rph_pkg::*;
#(
  parameter int HEADER_BYTES = 12
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire  [7:0]   in_data_byte,
  input  wire          in_packet_end,
  output logic         out_valid,
  input  wire          out_ready,
  output logic         out_is_marker,
  output logic [4:0]   out_chip_id,
  output logic [5:0]   out_channel,
  output logic [11:0]  out_bunch_id,
  output logic [9:0]   out_adc_value,
  output logic [7:0]   out_tdc_value,
  output logic         out_over_threshold,
  output logic [4:0]   out_trigger_offset,
  output logic [41:0]  out_marker_time,
  output logic [3:0]   out_board_id,
  output logic [31:0]  out_frame_count,
  output logic         out_header_bad
);

  logic rec_valid;
  logic rec_take;
  rec_t rec;

  rph_framer #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (in_data_byte),
    .packet_end(in_packet_end),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_take  (rec_take)
  );

  rph_decoder u_decoder (
    .clk               (clk),
    .rst_n             (rst_n),
    .rec_valid         (rec_valid),
    .rec               (rec),
    .rec_take          (rec_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_marker     (out_is_marker),
    .out_chip_id       (out_chip_id),
    .out_channel       (out_channel),
    .out_bunch_id      (out_bunch_id),
    .out_adc_value     (out_adc_value),
    .out_tdc_value     (out_tdc_value),
    .out_over_threshold(out_over_threshold),
    .out_trigger_offset(out_trigger_offset),
    .out_marker_time   (out_marker_time),
    .out_board_id      (out_board_id),
    .out_frame_count   (out_frame_count),
    .out_header_bad    (out_header_bad)
  );

`ifndef SYNTHESIS
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output side could take a result");

  a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_marker) |-> (out_channel == 6'd0 && out_adc_value == 10'd0
      && out_tdc_value == 8'd0 && out_bunch_id == 12'd0 && !out_over_threshold
      && out_trigger_offset == 5'd0))
    else $error("marker result carries hit fields");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_marker) |-> (out_marker_time == 42'd0))
    else $error("hit result carries a marker time");
`endif

endmodule

`default_nettype wire

/* rtl/rph_framer.sv */
// ----------------------------------------------------------------------------
// Readout packet framer
// Tracks header and record position, captures header fields and registers
// each finished six-byte record.
// ----------------------------------------------------------------------------
`default_nettype none

module rph_framer
  import rph_pkg::*;
#(
  parameter int HEADER_BYTES = 12
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] data_byte,
  input  wire        packet_end,
  output logic       rec_valid,
  output rec_t       rec,
  input  wire        rec_take
);

  localparam int CNT_W = $clog2(HEADER_BYTES);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_header_r, in_header_nxt;
  logic [31:0]      hdr_word_r, hdr_word_nxt;
  logic [31:0]      frame_r, frame_nxt;
  logic [3:0]       board_r, board_nxt;
  logic             bad_r, bad_nxt;
  logic [39:0]      rec_bytes_r, rec_bytes_nxt;
  logic             rec_valid_r, rec_valid_nxt;
  rec_t             rec_r, rec_nxt;
  logic             acc;
  logic             emit;
  logic [31:0]      w;

  assign in_ready = !rec_valid_r || rec_take;
  assign acc      = in_valid && in_ready;
  assign w        = {hdr_word_r[23:0], data_byte};

  always_comb begin
    cnt_nxt       = cnt_r;
    in_header_nxt = in_header_r;
    hdr_word_nxt  = hdr_word_r;
    frame_nxt     = frame_r;
    board_nxt     = board_r;
    bad_nxt       = bad_r;
    rec_bytes_nxt = rec_bytes_r;
    emit          = 1'b0;
    if (acc) begin
      if (in_header_r) begin
        hdr_word_nxt = w;
        if (cnt_r == CNT_W'(FRAME_LAST)) begin
          frame_nxt = w;
        end
        if (cnt_r == CNT_W'(ID_LAST)) begin
          if ((w & ID_MASK) == ID_MAGIC) begin
            board_nxt = w[7:4];
            bad_nxt   = 1'b0;
          end else begin
            bad_nxt = 1'b1;
          end
        end
        if (cnt_r == CNT_W'(HEADER_BYTES - 1)) begin
          in_header_nxt = 1'b0;
          cnt_nxt       = '0;
          rec_bytes_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (cnt_r == CNT_W'(RECORD_BYTES - 1)) begin
        emit          = 1'b1;
        cnt_nxt       = '0;
        rec_bytes_nxt = '0;
      end else begin
        rec_bytes_nxt = {rec_bytes_r[31:0], data_byte};
        cnt_nxt       = cnt_r + 1'b1;
      end
      if (packet_end) begin
        in_header_nxt = 1'b1;
        cnt_nxt       = '0;
        hdr_word_nxt  = '0;
        rec_bytes_nxt = '0;
      end
    end
  end

  always_comb begin
    rec_nxt.data1 = rec_bytes_r[39:8];
    rec_nxt.data2 = {rec_bytes_r[7:0], data_byte};
    rec_nxt.board = board_r;
    rec_nxt.frame = frame_r;
    rec_nxt.bad   = bad_r;
  end

  always_comb begin
    if (emit) begin
      rec_valid_nxt = 1'b1;
    end else if (rec_take) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      in_header_r <= 1'b1;
      hdr_word_r  <= '0;
      frame_r     <= '0;
      board_r     <= '0;
      bad_r       <= 1'b0;
      rec_bytes_r <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      in_header_r <= in_header_nxt;
      hdr_word_r  <= hdr_word_nxt;
      frame_r     <= frame_nxt;
      board_r     <= board_nxt;
      bad_r       <= bad_nxt;
      rec_bytes_r <= rec_bytes_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

endmodule

`default_nettype wire

/* rtl/rph_decoder.sv */
// ----------------------------------------------------------------------------
// Readout record decoder
// Splits a registered record into hit or marker fields and holds the result
// in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rph_decoder
  import rph_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          rec_valid,
  input  wire rec_t    rec,
  output logic         rec_take,
  output logic         out_valid,
  input  wire          out_ready,
  output logic         out_is_marker,
  output logic [4:0]   out_chip_id,
  output logic [5:0]   out_channel,
  output logic [11:0]  out_bunch_id,
  output logic [9:0]   out_adc_value,
  output logic [7:0]   out_tdc_value,
  output logic         out_over_threshold,
  output logic [4:0]   out_trigger_offset,
  output logic [41:0]  out_marker_time,
  output logic [3:0]   out_board_id,
  output logic [31:0]  out_frame_count,
  output logic         out_header_bad
);

  logic        out_valid_r, out_valid_nxt;
  logic        load;
  logic        hit;
  logic        is_marker_nxt;
  logic [4:0]  chip_nxt;
  logic [5:0]  channel_nxt;
  logic [11:0] bunch_nxt;
  logic [9:0]  adc_nxt;
  logic [7:0]  tdc_nxt;
  logic        thr_nxt;
  logic [4:0]  offset_nxt;
  logic [41:0] time_nxt;

  logic        is_marker_r;
  logic [4:0]  chip_r;
  logic [5:0]  channel_r;
  logic [11:0] bunch_r;
  logic [9:0]  adc_r;
  logic [7:0]  tdc_r;
  logic        thr_r;
  logic [4:0]  offset_r;
  logic [41:0] time_r;
  logic [3:0]  board_r;
  logic [31:0] frame_r;
  logic        bad_r;

  assign rec_take      = !out_valid_r || out_ready;
  assign load          = rec_valid && rec_take;
  assign out_valid_nxt = rec_take ? rec_valid : out_valid_r;
  assign hit           = rec.data2[15];

  always_comb begin
    is_marker_nxt = 1'b0;
    chip_nxt      = '0;
    channel_nxt   = '0;
    bunch_nxt     = '0;
    adc_nxt       = '0;
    tdc_nxt       = '0;
    thr_nxt       = 1'b0;
    offset_nxt    = '0;
    time_nxt      = '0;
    if (hit) begin
      chip_nxt    = rec.data1[26:22];
      channel_nxt = rec.data2[13:8];
      bunch_nxt   = gray_to_bin(rec.data1[11:0]);
      adc_nxt     = rec.data1[21:12];
      tdc_nxt     = rec.data2[7:0];
      thr_nxt     = rec.data2[14];
      offset_nxt  = rec.data1[31:27];
    end else begin
      is_marker_nxt = 1'b1;
      chip_nxt      = rec.data2[14:10];
      time_nxt      = {rec.data1, rec.data2[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_marker_r <= is_marker_nxt;
      chip_r      <= chip_nxt;
      channel_r   <= channel_nxt;
      bunch_r     <= bunch_nxt;
      adc_r       <= adc_nxt;
      tdc_r       <= tdc_nxt;
      thr_r       <= thr_nxt;
      offset_r    <= offset_nxt;
      time_r      <= time_nxt;
      board_r     <= rec.board;
      frame_r     <= rec.frame;
      bad_r       <= rec.bad;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_marker      = is_marker_r;
  assign out_chip_id        = chip_r;
  assign out_channel        = channel_r;
  assign out_bunch_id       = bunch_r;
  assign out_adc_value      = adc_r;
  assign out_tdc_value      = tdc_r;
  assign out_over_threshold = thr_r;
  assign out_trigger_offset = offset_r;
  assign out_marker_time    = time_r;
  assign out_board_id       = board_r;
  assign out_frame_count    = frame_r;
  assign out_header_bad     = bad_r;

endmodule

`default_nettype wire
